[hw/rtl/psrmv_pkg.sv]
// Shared types, sizes and codes of the per-slot running mean/variance core.
// No dependencies.
`timescale 1ns / 1ps
package psrmv_pkg;
  localparam int MaxClusters = 64;
  localparam int MaxMetrics  = 16;
  localparam int FracBits    = 16;
  localparam int Slots       = MaxClusters * MaxMetrics;
  localparam int SlotW       = $clog2(Slots);
  localparam int CfgW        = 7;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  // unused code, behaves as a read
  localparam logic [1:0] OP_SPARE  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  localparam logic       CFG_CLUSTERS = 1'b0;
  localparam logic       CFG_METRICS  = 1'b1;

  // one slot's accumulator word
  typedef struct packed {
    logic [31:0] cnt;
    logic [63:0] sum;
    logic [47:0] mean;
    logic [63:0] m2;
  } slot_t;

  // divider request and answer
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;
endpackage

[hw/rtl/psrmv_div.sv]
// Shared restoring divider: 64-bit unsigned dividend by 32-bit divisor,
// one quotient bit per cycle. Depends on psrmv_pkg.
`timescale 1ns / 1ps
module psrmv_div (
  input  logic                clk,
  input  logic                rst_n,
  input  psrmv_pkg::div_req_t req,
  output psrmv_pkg::div_rsp_t rsp
);
  logic [63:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  // shift one bit in, subtract when it fits
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[31:0], quo_r[63]};
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

  // a finished division always follows a busy period
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> $past(busy_r))
    else $error("divider done without busy");
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> cnt_r <= 7'd63)
    else $error("divider count overrun");
  assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == 7'd63 && !req.start) |=> done_r)
    else $error("divider did not finish");
endmodule

[hw/rtl/per_slot_running_mean_variance_core.sv]
// Per-slot running mean/variance core: sequencer, slot memory and multiplier.
// Depends on psrmv_pkg and psrmv_div.
`timescale 1ns / 1ps
// One beat in, one beat out. An update goes from the accepting edge to out_valid
// through the mean step and the variance step, each of which starts one
// 64-bit pass of the shared bit-serial divider; the 128-bit M2 product is formed
// from four 32x32 partial products, and the rest is sequencing. A read starts
// one divider pass; a clear and an out-of-range access do not use the divider.
// After reset the slot memory is swept clear, one slot a cycle, over all 1024
// slots, before the first beat is taken; configuration writes are taken at any
// time.
module per_slot_running_mean_variance_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [5:0]  in_cluster_index,
  input  logic [3:0]  in_metric_index,
  input  logic signed [31:0] in_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_count,
  output logic signed [63:0] out_total,
  output logic signed [47:0] out_mean,
  output logic [62:0] out_variance,
  output logic        out_variance_valid
);
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_LOAD  = 4'd3;
  localparam logic [3:0] S_MDIV  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_M2    = 4'd6;
  localparam logic [3:0] S_VDIV  = 4'd7;
  localparam logic [3:0] S_VWAIT = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_WR    = 4'd10;

  logic [3:0] st_r, st_nxt;
  logic [psrmv_pkg::SlotW-1:0] clr_r, clr_nxt;
  logic [6:0] ncl_r;
  logic [4:0] nmt_r;

  // slot memory
  psrmv_pkg::slot_t mem [psrmv_pkg::Slots];
  psrmv_pkg::slot_t rd_q;
  logic mem_we;
  logic [psrmv_pkg::SlotW-1:0] mem_wa;
  psrmv_pkg::slot_t mem_wd;

  // item registers
  logic [1:0]  op_r;
  logic [psrmv_pkg::SlotW-1:0] slot_r;
  logic signed [31:0] x_r;
  psrmv_pkg::slot_t sl_r, sl_nxt;
  logic signed [64:0] delta_r, delta_nxt;
  logic        dneg_r, dneg_nxt;
  logic [63:0] a_r, a_nxt, b_r, b_nxt;
  logic [1:0]  mph_r, mph_nxt;
  logic [127:0] prod_r, prod_nxt;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[slot_r];
  end

  // result register
  logic        ov_r, ov_nxt;
  logic [1:0]  os_r, os_nxt;
  logic [31:0] oc_r, oc_nxt;
  logic [63:0] ot_r, ot_nxt;
  logic [47:0] om_r, om_nxt;
  logic [62:0] ovr_r, ovr_nxt;
  logic        ovv_r, ovv_nxt;

  psrmv_pkg::div_req_t dreq;
  psrmv_pkg::div_rsp_t drsp;
  psrmv_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic        acc;
  logic [6:0]  climit;
  logic [4:0]  mlimit;
  logic signed [64:0] xq, nm_ext;
  logic [64:0] m2sum;
  logic [63:0] addv, qmag;
  logic [31:0] pa, pb;
  logic [63:0] pp;

  assign acc    = in_valid && !in_stall;
  assign climit = (ncl_r < 7'(psrmv_pkg::MaxClusters)) ? ncl_r : 7'(psrmv_pkg::MaxClusters);
  assign mlimit = (nmt_r < 5'(psrmv_pkg::MaxMetrics)) ? nmt_r : 5'(psrmv_pkg::MaxMetrics);
  assign in_stall = (st_r != S_IDLE) || ov_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncl_r <= 7'd64;
      nmt_r <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psrmv_pkg::CFG_CLUSTERS: ncl_r <= cfg_data;
        psrmv_pkg::CFG_METRICS:  nmt_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // accepted item
  always_ff @(posedge clk) begin
    if (acc) begin
      op_r   <= in_opcode;
      slot_r <= psrmv_pkg::SlotW'({in_cluster_index, in_metric_index});
      x_r    <= in_sample;
    end
  end

  // partial product operands: (a_lo|a_hi) x (b_lo|b_hi)
  assign pa = mph_r[0] ? a_r[63:32] : a_r[31:0];
  assign pb = mph_r[1] ? b_r[63:32] : b_r[31:0];
  assign pp = 64'(pa) * 64'(pb);

  assign xq     = 65'(x_r) <<< psrmv_pkg::FracBits;
  assign qmag   = drsp.quo;
  assign nm_ext = 65'($signed(sl_r.mean)) + (dneg_r ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag}));
  assign addv   = (prod_r[127:64+psrmv_pkg::FracBits] != '0) ? '1
                : prod_r[64+psrmv_pkg::FracBits-1:psrmv_pkg::FracBits];
  assign m2sum  = {1'b0, sl_r.m2} + {1'b0, addv};

  // sequencer
  always_comb begin
    st_nxt   = st_r;
    clr_nxt  = clr_r;
    sl_nxt   = sl_r;
    delta_nxt = delta_r;
    dneg_nxt = dneg_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    mph_nxt  = mph_r;
    prod_nxt = prod_r;
    ov_nxt   = ov_r && out_stall;
    os_nxt = os_r; oc_nxt = oc_r; ot_nxt = ot_r; om_nxt = om_r;
    ovr_nxt = ovr_r; ovv_nxt = ovv_r;
    mem_we = 1'b0;
    mem_wa = slot_r;
    mem_wd = sl_r;
    dreq   = '0;
    unique case (st_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          if ({1'b0, in_cluster_index} >= climit || {1'b0, in_metric_index} >= mlimit) begin
            ov_nxt = 1'b1; os_nxt = psrmv_pkg::ST_RANGE;
            oc_nxt = '0; ot_nxt = '0; om_nxt = '0; ovr_nxt = '0; ovv_nxt = 1'b0;
          end else begin
            st_nxt = S_RD;
          end
        end
      end
      S_RD: st_nxt = S_LOAD;
      S_LOAD: begin
        sl_nxt = rd_q;
        if (op_r == psrmv_pkg::OP_CLEAR) begin
          mem_we = 1'b1; mem_wd = '0;
          ov_nxt = 1'b1; os_nxt = psrmv_pkg::ST_OK;
          oc_nxt = '0; ot_nxt = '0; om_nxt = '0; ovr_nxt = '0; ovv_nxt = 1'b0;
          st_nxt = S_IDLE;
        end else if (op_r == psrmv_pkg::OP_UPDATE && rd_q.cnt != '1) begin
          sl_nxt.cnt = rd_q.cnt + 32'd1;
          delta_nxt = xq - 65'($signed(rd_q.mean));
          st_nxt = S_MDIV;
        end else if (op_r != psrmv_pkg::OP_UPDATE && rd_q.cnt == '0) begin
          ov_nxt = 1'b1; os_nxt = psrmv_pkg::ST_EMPTY;
          oc_nxt = '0; ot_nxt = '0; om_nxt = '0; ovr_nxt = '0; ovv_nxt = 1'b0;
          st_nxt = S_IDLE;
        end else begin
          st_nxt = S_VDIV;
        end
      end
      S_MDIV: begin
        // |delta| / n, sign applied after
        dreq.start = 1'b1;
        dreq.num = delta_r[64] ? 64'(-delta_r) : delta_r[63:0];
        dreq.den = sl_r.cnt;
        dneg_nxt = delta_r[64];
        st_nxt = S_MUL;
        mph_nxt = 2'd0;
      end
      S_MUL: begin
        if (drsp.done) begin
          sl_nxt.mean = nm_ext[47:0];
          sl_nxt.sum = sl_r.sum + 64'(x_r);
          a_nxt = delta_r[64] ? 64'(-delta_r) : delta_r[63:0];
          b_nxt = (xq - nm_ext) >= 0 ? 64'(xq - nm_ext) : 64'(nm_ext - xq);
          prod_nxt = '0;
          mph_nxt = 2'd0;
          st_nxt = S_M2;
        end
      end
      S_M2: begin
        prod_nxt = prod_r + (128'(pp) << (32 * (32'(mph_r[0]) + 32'(mph_r[1]))));
        mph_nxt = mph_r + 2'd1;
        if (mph_r == 2'd3) st_nxt = S_WR;
      end
      S_WR: begin
        sl_nxt.m2 = m2sum[64] ? '1 : m2sum[63:0];
        mem_we = 1'b1;
        mem_wd = sl_r;
        mem_wd.m2 = m2sum[64] ? '1 : m2sum[63:0];
        st_nxt = S_VDIV;
      end
      S_VDIV: begin
        dreq.start = 1'b1;
        dreq.num = sl_r.m2;
        dreq.den = sl_r.cnt - 32'd1;
        st_nxt = S_VWAIT;
      end
      S_VWAIT: if (drsp.done || sl_r.cnt < 32'd2) st_nxt = S_OUT;
      S_OUT: begin
        ov_nxt = 1'b1;
        os_nxt = (sl_r.cnt == '1) ? psrmv_pkg::ST_SAT : psrmv_pkg::ST_OK;
        oc_nxt = sl_r.cnt; ot_nxt = sl_r.sum; om_nxt = sl_r.mean;
        ovv_nxt = (sl_r.cnt >= 32'd2);
        ovr_nxt = (sl_r.cnt < 32'd2) ? '0 : (drsp.quo[63] ? '1 : drsp.quo[62:0]);
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_CLR;
      clr_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
      ov_r  <= ov_nxt;
    end
    sl_r <= sl_nxt; delta_r <= delta_nxt; dneg_r <= dneg_nxt;
    a_r <= a_nxt; b_r <= b_nxt; mph_r <= mph_nxt; prod_r <= prod_nxt;
    os_r <= os_nxt; oc_r <= oc_nxt; ot_r <= ot_nxt; om_r <= om_nxt;
    ovr_r <= ovr_nxt; ovv_r <= ovv_nxt;
  end

  assign out_valid = ov_r;
  assign out_status = os_r;
  assign out_count = oc_r;
  assign out_total = ot_r;
  assign out_mean = om_r;
  assign out_variance = ovr_r;
  assign out_variance_valid = ovv_r;

  // no beat taken during the clearing sweep
  assert property (@(posedge clk) disable iff (!rst_n) st_r == S_CLR |-> in_stall)
    else $error("beat taken during clear sweep");
  assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_variance_valid |-> out_count >= 32'd2)
    else $error("variance valid with fewer than two samples");
  assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_status == psrmv_pkg::ST_RANGE |-> out_count == '0)
    else $error("range error with nonzero count");
  assert property (@(posedge clk) disable iff (!rst_n) acc |=> !out_valid || $past(ov_r) == 1'b0)
    else $error("result raised while previous pending");
endmodule
